// ----- hdl/sdl_pkg.sv -----
// Package with the shared constants and types of the sorted deque list.
`timescale 1ns / 1ps

package sdl_pkg;

    localparam int NODE_DEPTH_DEF = 16;
    localparam int MODE_W         = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_SORTED    = 3'd0,
        MODE_PUSH_HEAD = 3'd1,
        MODE_PUSH_TAIL = 3'd2,
        MODE_POP_HEAD  = 3'd3,
        MODE_POP_TAIL  = 3'd4,
        MODE_REMOVE    = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH_FIX,
        S_POP_RD,
        S_POP_LINK,
        S_POP_FIX,
        S_WALK_HEAD,
        S_WALK_LINK,
        S_WALK,
        S_INS_W1,
        S_INS_W2,
        S_INS_W3,
        S_RMV_W1,
        S_RMV_FIX,
        S_RESP
    } state_t;

endpackage

// ----- hdl/sdl_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/sorted_deque_list.sv -----
// Top level of the sorted deque list: a bounded doubly linked list in node memories.
//
//   channel | direction | fields                                | transfer when
//   s_      | in        | mode, value                           | s_valid && s_ready
//   m_      | out       | removed_value, status, entry_count    | m_valid && m_ready
//
// A command is taken only in the idle state; a finished result waits in the output
// register while the next command is taken. Sorted insert and remove by value, when
// the value does not fall at either end, walk the list through the node memories at
// one node per cycle. Reset empties the list at once through the free map and the
// head and tail pointers. A stalled result holds the block in its response state
// until the output is free.
`timescale 1ns / 1ps

module sorted_deque_list #(
    parameter int NODE_DEPTH = sdl_pkg::NODE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sdl_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [sdl_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sdl_pkg::VALUE_W-1:0]  m_removed_value,
    output logic [sdl_pkg::STATUS_W-1:0]        m_status,
    output logic [sdl_pkg::COUNT_W-1:0]         m_entry_count
);

    localparam int AW = $clog2(NODE_DEPTH);
    localparam int PW = $clog2(NODE_DEPTH + 1);
    localparam int VW = sdl_pkg::VALUE_W;
    localparam int CW = sdl_pkg::COUNT_W;
    localparam logic [PW-1:0] NIL = PW'(NODE_DEPTH);

    sdl_pkg::state_t state_reg, state_next;

    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          tail_reg, tail_next;
    logic [PW-1:0]          count_reg, count_next;
    logic [NODE_DEPTH-1:0]  free_reg, free_next;
    logic signed [VW-1:0]   hval_reg, hval_next;
    logic signed [VW-1:0]   tval_reg, tval_next;
    logic signed [VW-1:0]   val_reg, val_next;
    logic                   side_reg, side_next;
    logic                   ins_reg, ins_next;
    logic [AW-1:0]          alloc_reg, alloc_next;
    logic [PW-1:0]          cur_reg, cur_next;
    logic signed [VW-1:0]   cur_val_reg, cur_val_next;
    logic [PW-1:0]          cur_prev_reg, cur_prev_next;
    logic [PW-1:0]          nx_reg, nx_next;
    logic [PW-1:0]          nxnext_reg, nxnext_next;
    logic [PW-1:0]          tgt_reg, tgt_next;
    logic signed [VW-1:0]   res_val_reg, res_val_next;
    logic [sdl_pkg::STATUS_W-1:0] res_st_reg, res_st_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [VW-1:0]   m_removed_value_reg, m_removed_value_next;
    logic [sdl_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CW-1:0]          m_entry_count_reg, m_entry_count_next;

    logic                   val_we;
    logic [AW-1:0]          val_waddr, val_raddr;
    logic [VW-1:0]          val_wdata, val_rdata;
    logic                   link_we;
    logic [AW-1:0]          link_waddr, link_raddr;
    logic [2*PW-1:0]        link_wdata, link_rdata;

    logic [PW-1:0]          lr_next, lr_prev;
    logic signed [VW-1:0]   vr;
    logic [AW-1:0]          lowest_free;
    logic                   accept;
    logic                   full;
    logic                   walk_match;
    logic                   resp_load;
    logic [PW-1:0]          pop_node, pop_nb;
    logic [CW+PW-1:0]       count_ext;

    sdl_ram #(.WIDTH(VW), .DEPTH(NODE_DEPTH)) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    sdl_ram #(.WIDTH(2 * PW), .DEPTH(NODE_DEPTH)) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign lr_next    = link_rdata[2*PW-1:PW];
    assign lr_prev    = link_rdata[PW-1:0];
    assign vr         = $signed(val_rdata);
    assign s_ready    = (state_reg == sdl_pkg::S_IDLE);
    assign accept     = s_valid && s_ready;
    assign full       = (count_reg >= NIL);
    assign walk_match = ins_reg ? ((val_reg >= cur_val_reg) && (val_reg <= vr))
                                : (vr == val_reg);
    assign resp_load  = (state_reg == sdl_pkg::S_RESP) && (!m_valid_reg || m_ready);
    assign pop_node   = side_reg ? tail_reg : head_reg;
    assign pop_nb     = side_reg ? lr_prev : lr_next;
    assign count_ext  = {{CW{1'b0}}, count_reg};

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_status        = m_status_reg;
    assign m_entry_count   = m_entry_count_reg;

    always_comb begin
        lowest_free = '0;
        for (int i = NODE_DEPTH - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                lowest_free = AW'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sdl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_mode)
                        sdl_pkg::MODE_SORTED: begin
                            if (full) begin
                                state_next = sdl_pkg::S_RESP;
                            end else if (head_reg == NIL || s_value <= hval_reg
                                         || s_value >= tval_reg) begin
                                state_next = sdl_pkg::S_PUSH;
                            end else begin
                                state_next = sdl_pkg::S_WALK_HEAD;
                            end
                        end
                        sdl_pkg::MODE_PUSH_HEAD, sdl_pkg::MODE_PUSH_TAIL: begin
                            state_next = full ? sdl_pkg::S_RESP : sdl_pkg::S_PUSH;
                        end
                        sdl_pkg::MODE_POP_HEAD, sdl_pkg::MODE_POP_TAIL: begin
                            state_next = (head_reg == NIL) ? sdl_pkg::S_RESP
                                                           : sdl_pkg::S_POP_RD;
                        end
                        sdl_pkg::MODE_REMOVE: begin
                            if (head_reg == NIL) begin
                                state_next = sdl_pkg::S_RESP;
                            end else if (s_value == hval_reg || s_value == tval_reg) begin
                                state_next = sdl_pkg::S_POP_RD;
                            end else begin
                                state_next = sdl_pkg::S_WALK_HEAD;
                            end
                        end
                        default: state_next = sdl_pkg::S_RESP;
                    endcase
                end
            end
            sdl_pkg::S_PUSH: begin
                state_next = ((side_reg ? tail_reg : head_reg) == NIL) ? sdl_pkg::S_RESP
                                                                      : sdl_pkg::S_PUSH_FIX;
            end
            sdl_pkg::S_PUSH_FIX:  state_next = sdl_pkg::S_RESP;
            sdl_pkg::S_POP_RD:    state_next = sdl_pkg::S_POP_LINK;
            sdl_pkg::S_POP_LINK: begin
                state_next = (pop_nb == NIL) ? sdl_pkg::S_RESP : sdl_pkg::S_POP_FIX;
            end
            sdl_pkg::S_POP_FIX:   state_next = sdl_pkg::S_RESP;
            sdl_pkg::S_WALK_HEAD: state_next = sdl_pkg::S_WALK_LINK;
            sdl_pkg::S_WALK_LINK: begin
                state_next = (lr_next == NIL) ? sdl_pkg::S_RESP : sdl_pkg::S_WALK;
            end
            sdl_pkg::S_WALK: begin
                if (walk_match) begin
                    state_next = ins_reg ? sdl_pkg::S_INS_W1 : sdl_pkg::S_RMV_W1;
                end else if (lr_next == NIL) begin
                    state_next = sdl_pkg::S_RESP;
                end
            end
            sdl_pkg::S_INS_W1: state_next = sdl_pkg::S_INS_W2;
            sdl_pkg::S_INS_W2: state_next = sdl_pkg::S_INS_W3;
            sdl_pkg::S_INS_W3: state_next = sdl_pkg::S_RESP;
            sdl_pkg::S_RMV_W1: begin
                state_next = (nxnext_reg == NIL) ? sdl_pkg::S_RESP : sdl_pkg::S_RMV_FIX;
            end
            sdl_pkg::S_RMV_FIX: state_next = sdl_pkg::S_RESP;
            sdl_pkg::S_RESP: begin
                if (resp_load) begin
                    state_next = sdl_pkg::S_IDLE;
                end
            end
            default: state_next = sdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        val_we     = 1'b0;
        val_waddr  = alloc_reg;
        val_wdata  = val_reg;
        val_raddr  = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        unique case (state_reg)
            sdl_pkg::S_PUSH: begin
                val_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = alloc_reg;
                link_wdata = side_reg ? {NIL, tail_reg} : {head_reg, NIL};
                link_raddr = side_reg ? tail_reg[AW-1:0] : head_reg[AW-1:0];
            end
            sdl_pkg::S_PUSH_FIX: begin
                link_we    = 1'b1;
                link_waddr = tgt_reg[AW-1:0];
                link_wdata = side_reg ? {PW'(alloc_reg), lr_prev}
                                      : {lr_next, PW'(alloc_reg)};
            end
            sdl_pkg::S_POP_RD: begin
                link_raddr = pop_node[AW-1:0];
            end
            sdl_pkg::S_POP_LINK: begin
                val_raddr  = pop_nb[AW-1:0];
                link_raddr = pop_nb[AW-1:0];
            end
            sdl_pkg::S_POP_FIX: begin
                link_we    = 1'b1;
                link_waddr = tgt_reg[AW-1:0];
                link_wdata = side_reg ? {NIL, lr_prev} : {lr_next, NIL};
            end
            sdl_pkg::S_WALK_HEAD: begin
                link_raddr = head_reg[AW-1:0];
            end
            sdl_pkg::S_WALK_LINK: begin
                val_raddr  = lr_next[AW-1:0];
                link_raddr = lr_next[AW-1:0];
            end
            sdl_pkg::S_WALK: begin
                val_raddr  = lr_next[AW-1:0];
                link_raddr = lr_next[AW-1:0];
            end
            sdl_pkg::S_INS_W1: begin
                val_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = alloc_reg;
                link_wdata = {nx_reg, cur_reg};
            end
            sdl_pkg::S_INS_W2: begin
                link_we    = 1'b1;
                link_waddr = nx_reg[AW-1:0];
                link_wdata = {nxnext_reg, PW'(alloc_reg)};
            end
            sdl_pkg::S_INS_W3: begin
                link_we    = 1'b1;
                link_waddr = cur_reg[AW-1:0];
                link_wdata = {PW'(alloc_reg), cur_prev_reg};
            end
            sdl_pkg::S_RMV_W1: begin
                link_we    = 1'b1;
                link_waddr = cur_reg[AW-1:0];
                link_wdata = {nxnext_reg, cur_prev_reg};
                link_raddr = nxnext_reg[AW-1:0];
            end
            sdl_pkg::S_RMV_FIX: begin
                link_we    = 1'b1;
                link_waddr = nxnext_reg[AW-1:0];
                link_wdata = {lr_next, cur_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        head_next            = head_reg;
        tail_next            = tail_reg;
        count_next           = count_reg;
        free_next            = free_reg;
        hval_next            = hval_reg;
        tval_next            = tval_reg;
        val_next             = val_reg;
        side_next            = side_reg;
        ins_next             = ins_reg;
        alloc_next           = alloc_reg;
        cur_next             = cur_reg;
        cur_val_next         = cur_val_reg;
        cur_prev_next        = cur_prev_reg;
        nx_next              = nx_reg;
        nxnext_next          = nxnext_reg;
        tgt_next             = tgt_reg;
        res_val_next         = res_val_reg;
        res_st_next          = res_st_reg;
        m_valid_next         = m_valid_reg;
        m_removed_value_next = m_removed_value_reg;
        m_status_next        = m_status_reg;
        m_entry_count_next   = m_entry_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            sdl_pkg::S_IDLE: begin
                if (accept) begin
                    val_next     = s_value;
                    alloc_next   = lowest_free;
                    res_val_next = '0;
                    res_st_next  = sdl_pkg::ST_OK;
                    side_next    = 1'b0;
                    unique case (s_mode)
                        sdl_pkg::MODE_SORTED: begin
                            ins_next = 1'b1;
                            if (full) begin
                                res_st_next = sdl_pkg::ST_FULL;
                            end else if (head_reg != NIL && s_value > hval_reg
                                         && s_value >= tval_reg) begin
                                side_next = 1'b1;
                            end
                        end
                        sdl_pkg::MODE_PUSH_HEAD, sdl_pkg::MODE_PUSH_TAIL: begin
                            side_next = (s_mode == sdl_pkg::MODE_PUSH_TAIL);
                            if (full) begin
                                res_st_next = sdl_pkg::ST_FULL;
                            end
                        end
                        sdl_pkg::MODE_POP_HEAD, sdl_pkg::MODE_POP_TAIL: begin
                            side_next = (s_mode == sdl_pkg::MODE_POP_TAIL);
                            if (head_reg == NIL) begin
                                res_st_next = sdl_pkg::ST_EMPTY;
                            end
                        end
                        sdl_pkg::MODE_REMOVE: begin
                            ins_next  = 1'b0;
                            side_next = (s_value != hval_reg);
                            if (head_reg == NIL) begin
                                res_st_next = sdl_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sdl_pkg::S_PUSH: begin
                free_next[alloc_reg] = 1'b0;
                count_next = count_reg + PW'(1);
                if (side_reg) begin
                    tail_next = PW'(alloc_reg);
                    tval_next = val_reg;
                    tgt_next  = tail_reg;
                    if (tail_reg == NIL) begin
                        head_next = PW'(alloc_reg);
                        hval_next = val_reg;
                    end
                end else begin
                    head_next = PW'(alloc_reg);
                    hval_next = val_reg;
                    tgt_next  = head_reg;
                    if (head_reg == NIL) begin
                        tail_next = PW'(alloc_reg);
                        tval_next = val_reg;
                    end
                end
            end
            sdl_pkg::S_POP_LINK: begin
                free_next[pop_node[AW-1:0]] = 1'b1;
                count_next   = count_reg - PW'(1);
                res_val_next = side_reg ? tval_reg : hval_reg;
                tgt_next     = pop_nb;
                if (pop_nb == NIL) begin
                    head_next = NIL;
                    tail_next = NIL;
                end else if (side_reg) begin
                    tail_next = pop_nb;
                end else begin
                    head_next = pop_nb;
                end
            end
            sdl_pkg::S_POP_FIX: begin
                if (side_reg) begin
                    tval_next = vr;
                end else begin
                    hval_next = vr;
                end
            end
            sdl_pkg::S_WALK_HEAD: begin
                cur_next     = head_reg;
                cur_val_next = hval_reg;
            end
            sdl_pkg::S_WALK_LINK: begin
                cur_prev_next = lr_prev;
                nx_next       = lr_next;
                if (lr_next == NIL) begin
                    res_st_next = sdl_pkg::ST_NOT_FOUND;
                end
            end
            sdl_pkg::S_WALK: begin
                if (walk_match) begin
                    nxnext_next = lr_next;
                    if (!ins_reg) begin
                        free_next[nx_reg[AW-1:0]] = 1'b1;
                        count_next   = count_reg - PW'(1);
                        res_val_next = val_reg;
                    end
                end else begin
                    cur_next      = nx_reg;
                    cur_val_next  = vr;
                    cur_prev_next = lr_prev;
                    nx_next       = lr_next;
                    if (lr_next == NIL) begin
                        res_st_next = sdl_pkg::ST_NOT_FOUND;
                    end
                end
            end
            sdl_pkg::S_INS_W1: begin
                free_next[alloc_reg] = 1'b0;
                count_next = count_reg + PW'(1);
            end
            sdl_pkg::S_RESP: begin
                if (resp_load) begin
                    m_valid_next         = 1'b1;
                    m_removed_value_next = res_val_reg;
                    m_status_next        = res_st_reg;
                    m_entry_count_next   = count_ext[CW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdl_pkg::S_IDLE;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            count_reg   <= '0;
            free_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hval_reg            <= hval_next;
        tval_reg            <= tval_next;
        val_reg             <= val_next;
        side_reg            <= side_next;
        ins_reg             <= ins_next;
        alloc_reg           <= alloc_next;
        cur_reg             <= cur_next;
        cur_val_reg         <= cur_val_next;
        cur_prev_reg        <= cur_prev_next;
        nx_reg              <= nx_next;
        nxnext_reg          <= nxnext_next;
        tgt_reg             <= tgt_next;
        res_val_reg         <= res_val_next;
        res_st_reg          <= res_st_next;
        m_removed_value_reg <= m_removed_value_next;
        m_status_reg        <= m_status_next;
        m_entry_count_reg   <= m_entry_count_next;
    end

endmodule

// ----- bench/list_result_monitor.sv -----
// Result monitor for the sorted deque list: predicts each command's response and compares it.
`timescale 1ns / 1ps

module list_result_monitor #(
    parameter int NODE_DEPTH = sdl_pkg::NODE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [sdl_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [sdl_pkg::VALUE_W-1:0]  s_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [sdl_pkg::VALUE_W-1:0]  m_removed_value,
    input  logic [sdl_pkg::STATUS_W-1:0]        m_status,
    input  logic [sdl_pkg::COUNT_W-1:0]         m_entry_count,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen,
    output int                                  empty_seen,
    output int                                  full_seen,
    output int                                  missing_seen
);

    typedef struct packed {
        logic signed [sdl_pkg::VALUE_W-1:0] removed;
        sdl_pkg::status_t                   status;
        logic [sdl_pkg::COUNT_W-1:0]        count;
    } list_result_t;

    logic signed [sdl_pkg::VALUE_W-1:0] list_vals[$];
    list_result_t                       pending_results[$];

    int errs    = 0;
    int rslts   = 0;
    int empties = 0;
    int fulls   = 0;
    int misses  = 0;

    assign mismatches   = errs;
    assign results_seen = rslts;
    assign empty_seen   = empties;
    assign full_seen    = fulls;
    assign missing_seen = misses;

    // Applies one command to the shadow list and returns the response it should give.
    function automatic list_result_t apply_cmd(input logic [sdl_pkg::MODE_W-1:0] mode,
                                               input logic signed [sdl_pkg::VALUE_W-1:0] value);
        list_result_t r;
        int n;
        int slot;
        r.removed = '0;
        r.status  = sdl_pkg::ST_OK;
        n         = list_vals.size();
        slot      = -1;
        case (mode)
            sdl_pkg::MODE_SORTED: begin
                if (n >= NODE_DEPTH) begin
                    r.status = sdl_pkg::ST_FULL;
                end else if (n == 0 || value <= list_vals[0]) begin
                    list_vals.push_front(value);
                end else if (value >= list_vals[n-1]) begin
                    list_vals.push_back(value);
                end else begin
                    for (int i = 0; i + 1 < n && slot < 0; i++) begin
                        if (value >= list_vals[i] && value <= list_vals[i+1]) slot = i + 1;
                    end
                    if (slot < 0) r.status = sdl_pkg::ST_NOT_FOUND;
                    else list_vals.insert(slot, value);
                end
            end
            sdl_pkg::MODE_PUSH_HEAD, sdl_pkg::MODE_PUSH_TAIL: begin
                if (n >= NODE_DEPTH) r.status = sdl_pkg::ST_FULL;
                else if (mode == sdl_pkg::MODE_PUSH_HEAD) list_vals.push_front(value);
                else list_vals.push_back(value);
            end
            sdl_pkg::MODE_POP_HEAD, sdl_pkg::MODE_POP_TAIL: begin
                if (n == 0) r.status = sdl_pkg::ST_EMPTY;
                else if (mode == sdl_pkg::MODE_POP_HEAD) r.removed = list_vals.pop_front();
                else r.removed = list_vals.pop_back();
            end
            sdl_pkg::MODE_REMOVE: begin
                if (n == 0) begin
                    r.status = sdl_pkg::ST_EMPTY;
                end else if (value == list_vals[0]) begin
                    r.removed = list_vals.pop_front();
                end else if (value == list_vals[n-1]) begin
                    r.removed = list_vals.pop_back();
                end else begin
                    for (int i = 0; i < n && slot < 0; i++) begin
                        if (list_vals[i] == value) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = sdl_pkg::ST_NOT_FOUND;
                    end else begin
                        r.removed = value;
                        list_vals.delete(slot);
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = sdl_pkg::COUNT_W'(list_vals.size());
        return r;
    endfunction

    task automatic flag_error(input string what);
        errs++;
        if (errs <= 10) $display("mismatch %0d at %0t: %s", errs, $time, what);
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            list_vals.delete();
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                rslts++;
                if (m_status == sdl_pkg::ST_EMPTY) empties++;
                if (m_status == sdl_pkg::ST_FULL) fulls++;
                if (m_status == sdl_pkg::ST_NOT_FOUND) misses++;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf({"result with nothing expected: ",
                                          "value %0d status %0d count %0d"},
                                         m_removed_value, m_status, m_entry_count));
                end else begin
                    want = pending_results.pop_front();
                    if (m_removed_value !== want.removed || m_status !== want.status ||
                        m_entry_count !== want.count) begin
                        flag_error($sformatf({"expected value %0d status %0d count %0d, ",
                                              "got value %0d status %0d count %0d"},
                                             want.removed, want.status, want.count,
                                             m_removed_value, m_status, m_entry_count));
                    end
                end
            end
            if (s_valid && s_ready) pending_results.push_back(apply_cmd(s_mode, s_value));
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the sorted deque list testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 1230;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [sdl_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [sdl_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam logic signed [sdl_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sdl_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [sdl_pkg::MODE_W-1:0]          s_mode;
    logic signed [sdl_pkg::VALUE_W-1:0]  s_value;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [sdl_pkg::VALUE_W-1:0]  m_removed_value;
    logic [sdl_pkg::STATUS_W-1:0]        m_status;
    logic [sdl_pkg::COUNT_W-1:0]         m_entry_count;

    int mismatches;
    int outstanding;
    int results_seen;
    int empty_seen;
    int full_seen;
    int missing_seen;

    int cycle_count   = 0;
    int sent_count    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    bit sender_paced  = 1'b1;
    bit sink_paced    = 1'b1;

    sorted_deque_list u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_entry_count   (m_entry_count)
    );

    list_result_monitor u_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_entry_count   (m_entry_count),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .empty_seen      (empty_seen),
        .full_seen       (full_seen),
        .missing_seen    (missing_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offers one command and returns at the edge where its transfer happens.
    task automatic send_cmd(input logic [sdl_pkg::MODE_W-1:0] mode,
                            input logic signed [sdl_pkg::VALUE_W-1:0] value);
        int gap;
        gap = (sender_paced && burst_left == 0) ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    function automatic logic signed [sdl_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return int'($urandom_range(0, 16)) - 8;
        if (sel < 9) return $urandom;
        return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    endfunction

    function automatic logic [sdl_pkg::MODE_W-1:0] pick_mode(input int insert_pct);
        int sel;
        if ($urandom_range(0, 99) < 2) return $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < insert_pct) begin
            if (sel < 6) return sdl_pkg::MODE_SORTED;
            if (sel < 8) return sdl_pkg::MODE_PUSH_HEAD;
            return sdl_pkg::MODE_PUSH_TAIL;
        end
        if (sel < 3) return sdl_pkg::MODE_POP_HEAD;
        if (sel < 6) return sdl_pkg::MODE_POP_TAIL;
        return sdl_pkg::MODE_REMOVE;
    endfunction

    initial begin
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 59) == 0) sink_paced = !sink_paced;
            stall = sink_paced ? $urandom_range(0, 8) : 0;
            if (hold_requests != holds_served) begin
                holds_served++;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int episode_left;
        int insert_pct;
        episode_left = 0;
        insert_pct   = 50;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mode  <= sdl_pkg::MODE_SORTED;
        s_value <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty list, unused modes, ordered inserts, every kind of removal.
        send_cmd(sdl_pkg::MODE_POP_HEAD, 32'sd0);
        send_cmd(sdl_pkg::MODE_POP_TAIL, 32'sd0);
        send_cmd(sdl_pkg::MODE_REMOVE, 32'sd5);
        send_cmd(MODE_SPARE_A, 32'sd9);
        send_cmd(MODE_SPARE_B, VAL_MAX);
        send_cmd(sdl_pkg::MODE_SORTED, 32'sd0);
        send_cmd(sdl_pkg::MODE_SORTED, VAL_MAX);
        send_cmd(sdl_pkg::MODE_SORTED, VAL_MIN);
        send_cmd(sdl_pkg::MODE_SORTED, 32'sd100);
        send_cmd(sdl_pkg::MODE_SORTED, 32'sd100);
        send_cmd(sdl_pkg::MODE_REMOVE, 32'sd100);
        send_cmd(sdl_pkg::MODE_REMOVE, 32'sd12345);
        send_cmd(sdl_pkg::MODE_REMOVE, VAL_MIN);
        send_cmd(sdl_pkg::MODE_REMOVE, VAL_MAX);
        send_cmd(sdl_pkg::MODE_PUSH_HEAD, -32'sd1);
        send_cmd(sdl_pkg::MODE_PUSH_TAIL, 32'shAAAA_AAAA);
        send_cmd(sdl_pkg::MODE_POP_HEAD, 32'sh5555_5555);
        send_cmd(sdl_pkg::MODE_POP_TAIL, VAL_MIN);
        send_cmd(sdl_pkg::MODE_POP_TAIL, 32'sd0);
        send_cmd(sdl_pkg::MODE_POP_HEAD, 32'sd0);

        // Random part in episodes that lean toward filling or draining the list.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (episode_left == 0) begin
                episode_left = $urandom_range(30, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
                sender_paced = ($urandom_range(0, 3) != 0);
            end
            episode_left--;
            if (i == HOLD_AT_ITEM) begin
                hold_requests++;
                burst_left = 24;
            end
            send_cmd(pick_mode(insert_pct), pick_value());
            if (burst_left > 0) burst_left--;
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands and checked %0d responses in %0d cycles.",
                 sent_count, results_seen, cycle_count);
        $display({"Responses included %0d empty, %0d full and %0d not-found, ",
                  "with %0d long hold-off."},
                 empty_seen, full_seen, missing_seen, holds_served);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
